### hw/rtl/text_console_char_writer_macros.svh
// assertion macros for the text console writer
`ifndef TEXT_CONSOLE_CHAR_WRITER_MACROS_SVH
`define TEXT_CONSOLE_CHAR_WRITER_MACROS_SVH

`ifndef NO_ASSERTIONS

`define TCW_ASSERT_IMPL(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("text console check failed");

`define TCW_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("text console check failed");

`else

`define TCW_ASSERT_IMPL(name, ante, cons)

`define TCW_ASSERT_NEXT(name, ante, cons)

`endif

`endif

### hw/rtl/tcw_pkg.sv
// shared types and constants of the text console writer
package tcw_pkg;

    localparam int COL_W   = 7;
    localparam int ROW_W   = 5;
    localparam int CHAR_W  = 8;
    localparam int PADDR_W = 3;

    localparam logic [1:0] ACT_PUT    = 2'd0;
    localparam logic [1:0] ACT_CLEAR  = 2'd1;
    localparam logic [1:0] ACT_SETCUR = 2'd2;
    localparam logic [1:0] ACT_READ   = 2'd3;

    localparam logic [CHAR_W-1:0] CH_TAB     = 8'd9;
    localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'd10;
    localparam logic [CHAR_W-1:0] CH_RETURN  = 8'd13;
    localparam logic [CHAR_W-1:0] CH_SPACE   = 8'd32;

    localparam logic [CHAR_W-1:0] RESET_COLOR = 8'd7;

    // word index of the color register
    localparam logic REG_TEXT_COLOR = 1'b0;

    typedef struct packed {
        logic [1:0]        action;
        logic [CHAR_W-1:0] char_code;
        logic [COL_W-1:0]  col_in;
        logic [ROW_W-1:0]  row_in;
    } tcw_in_t;

    typedef struct packed {
        logic [COL_W-1:0]  cursor_col;
        logic [ROW_W-1:0]  cursor_row;
        logic [CHAR_W-1:0] cell_char;
        logic [CHAR_W-1:0] cell_color;
    } tcw_out_t;

endpackage

### hw/rtl/tcw_ram.sv
// generic single-port ram with registered read
module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 3200
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

### hw/rtl/tcw_apb.sv
// apb register port holding the text color
module tcw_apb
    import tcw_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output logic [CHAR_W-1:0]  text_color
);

    logic [CHAR_W-1:0] color_reg;
    logic [CHAR_W-1:0] color_next;
    logic              hit;

    assign hit    = (paddr[PADDR_W-1:2] == REG_TEXT_COLOR);
    assign pready = 1'b1;

    always_comb
    begin
        color_next = color_reg;
        if (psel && penable && pwrite && hit)
        begin
            color_next = pwdata[CHAR_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            color_reg <= RESET_COLOR;
        end
        else
        begin
            color_reg <= color_next;
        end
    end

    assign prdata     = hit ? {{(32-CHAR_W){1'b0}}, color_reg} : 32'd0;
    assign text_color = color_reg;

endmodule

### hw/rtl/tcw_ctrl.sv
// sequencer: cursor, row ring and read/write/fill of the cell memory
module tcw_ctrl
    import tcw_pkg::*;
#(
    parameter int COLUMNS    = 80,
    parameter int ROWS       = 25,
    parameter int TAB_SPACES = 4,
    parameter int AW         = 12
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_stall,
    input  tcw_in_t             item,
    input  logic [CHAR_W-1:0]   text_color,
    input  logic                out_free,
    output logic                done,
    output tcw_out_t            res,
    output logic                ram_we,
    output logic [AW-1:0]       ram_addr,
    output logic [2*CHAR_W-1:0] ram_wdata,
    input  logic [2*CHAR_W-1:0] ram_rdata
);

    localparam int CW = $clog2(COLUMNS);
    localparam int RW = $clog2(ROWS);
    localparam int TW = $clog2(TAB_SPACES + 1);

    localparam logic [COL_W-1:0] LAST_COL = COL_W'(COLUMNS - 1);
    localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS - 1);
    localparam logic [COL_W:0]   COLS_X   = (COL_W+1)'(COLUMNS);
    localparam logic [ROW_W:0]   ROWS_X   = (ROW_W+1)'(ROWS);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXEC = 3'd1;
    localparam logic [2:0] S_TAB  = 3'd2;
    localparam logic [2:0] S_READ = 3'd3;
    localparam logic [2:0] S_FILL = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    logic [2:0]        state_reg, state_next;
    tcw_in_t           item_reg, item_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [ROW_W-1:0]  top_reg, top_next;
    logic [TW-1:0]     tab_cnt_reg, tab_cnt_next;
    logic              ovf_reg, ovf_next;
    logic [ROW_W-1:0]  fill_row_reg, fill_row_next;
    logic [COL_W-1:0]  fill_col_reg, fill_col_next;
    logic [ROW_W-1:0]  fill_last_reg, fill_last_next;
    logic [CHAR_W-1:0] fill_color_reg, fill_color_next;
    logic              fill_emit_reg, fill_emit_next;
    logic [CHAR_W-1:0] rd_char_reg, rd_char_next;
    logic [CHAR_W-1:0] rd_color_reg, rd_color_next;

    logic              use_item_pos;
    logic [COL_W-1:0]  src_col;
    logic [ROW_W-1:0]  src_row;
    logic [ROW_W:0]    row_sum;
    logic [ROW_W-1:0]  phys_row;
    logic [AW-1:0]     cur_addr;
    logic              in_range;
    logic              finish;
    logic              start_scroll;

    // the screen is a ring of rows: logical row 0 sits at physical row top_reg
    assign use_item_pos = (state_reg == S_EXEC) && (item_reg.action == ACT_READ);
    assign src_col  = use_item_pos ? item_reg.col_in : col_reg;
    assign src_row  = use_item_pos ? item_reg.row_in : row_reg;
    assign row_sum  = {1'b0, src_row} + {1'b0, top_reg};
    assign phys_row = (row_sum >= ROWS_X) ? ROW_W'(row_sum - ROWS_X) : row_sum[ROW_W-1:0];
    assign cur_addr = {phys_row[RW-1:0], src_col[CW-1:0]};
    assign in_range = ({1'b0, item_reg.col_in} < COLS_X) && ({1'b0, item_reg.row_in} < ROWS_X);

    assign item_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next      = state_reg;
        item_next       = item_reg;
        col_next        = col_reg;
        row_next        = row_reg;
        top_next        = top_reg;
        tab_cnt_next    = tab_cnt_reg;
        ovf_next        = ovf_reg;
        fill_row_next   = fill_row_reg;
        fill_col_next   = fill_col_reg;
        fill_last_next  = fill_last_reg;
        fill_color_next = fill_color_reg;
        fill_emit_next  = fill_emit_reg;
        rd_char_next    = rd_char_reg;
        rd_color_next   = rd_color_reg;
        ram_we          = 1'b0;
        ram_addr        = cur_addr;
        ram_wdata       = {text_color, CH_SPACE};
        finish          = 1'b0;
        start_scroll    = 1'b0;
        done            = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    item_next  = item;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                rd_char_next  = '0;
                rd_color_next = '0;
                unique case (item_reg.action)
                    ACT_PUT:
                    begin
                        unique case (item_reg.char_code)
                            CH_NEWLINE:
                            begin
                                col_next = '0;
                                if (row_reg == LAST_ROW)
                                begin
                                    start_scroll = 1'b1;
                                end
                                else
                                begin
                                    row_next = row_reg + ROW_W'(1);
                                    finish   = 1'b1;
                                end
                            end
                            CH_RETURN:
                            begin
                                col_next = '0;
                                finish   = 1'b1;
                            end
                            CH_TAB:
                            begin
                                tab_cnt_next = TW'(TAB_SPACES);
                                ovf_next     = 1'b0;
                                state_next   = S_TAB;
                            end
                            default:
                            begin
                                ram_we    = 1'b1;
                                ram_wdata = {text_color, item_reg.char_code};
                                if (col_reg == LAST_COL)
                                begin
                                    col_next = '0;
                                    if (row_reg == LAST_ROW)
                                    begin
                                        start_scroll = 1'b1;
                                    end
                                    else
                                    begin
                                        row_next = row_reg + ROW_W'(1);
                                        finish   = 1'b1;
                                    end
                                end
                                else
                                begin
                                    col_next = col_reg + COL_W'(1);
                                    finish   = 1'b1;
                                end
                            end
                        endcase
                    end
                    ACT_CLEAR:
                    begin
                        col_next        = '0;
                        row_next        = '0;
                        top_next        = '0;
                        fill_row_next   = '0;
                        fill_col_next   = '0;
                        fill_last_next  = LAST_ROW;
                        fill_color_next = text_color;
                        fill_emit_next  = 1'b1;
                        state_next      = S_FILL;
                    end
                    ACT_SETCUR:
                    begin
                        if (in_range)
                        begin
                            col_next = item_reg.col_in;
                            row_next = item_reg.row_in;
                        end
                        finish = 1'b1;
                    end
                    ACT_READ:
                    begin
                        state_next = S_READ;
                    end
                endcase
            end
            S_READ:
            begin
                if (in_range)
                begin
                    rd_char_next  = ram_rdata[CHAR_W-1:0];
                    rd_color_next = ram_rdata[2*CHAR_W-1:CHAR_W];
                end
                finish = 1'b1;
            end
            S_TAB:
            begin
                // once the row has run past the bottom, the remaining spaces are dropped
                ram_we       = !ovf_reg;
                tab_cnt_next = tab_cnt_reg - TW'(1);
                if (col_reg == LAST_COL)
                begin
                    col_next = '0;
                    if (row_reg == LAST_ROW)
                    begin
                        ovf_next = 1'b1;
                    end
                    else
                    begin
                        row_next = row_reg + ROW_W'(1);
                    end
                end
                else
                begin
                    col_next = col_reg + COL_W'(1);
                end
                if (tab_cnt_reg == TW'(1))
                begin
                    if (ovf_next)
                    begin
                        start_scroll = 1'b1;
                    end
                    else
                    begin
                        finish = 1'b1;
                    end
                end
            end
            S_FILL:
            begin
                ram_we    = 1'b1;
                ram_addr  = {fill_row_reg[RW-1:0], fill_col_reg[CW-1:0]};
                ram_wdata = {fill_color_reg, CH_SPACE};
                if (fill_col_reg == LAST_COL)
                begin
                    fill_col_next = '0;
                    if (fill_row_reg == fill_last_reg)
                    begin
                        if (fill_emit_reg)
                        begin
                            finish = 1'b1;
                        end
                        else
                        begin
                            state_next = S_IDLE;
                        end
                    end
                    else
                    begin
                        fill_row_next = fill_row_reg + ROW_W'(1);
                    end
                end
                else
                begin
                    fill_col_next = fill_col_reg + COL_W'(1);
                end
            end
            S_DONE:
            begin
                finish = 1'b1;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // scroll: the old top row becomes the new bottom row and is blanked
        if (start_scroll)
        begin
            fill_row_next   = top_reg;
            fill_last_next  = top_reg;
            fill_col_next   = '0;
            fill_color_next = text_color;
            fill_emit_next  = 1'b1;
            top_next        = (top_reg == LAST_ROW) ? '0 : top_reg + ROW_W'(1);
            row_next        = LAST_ROW;
            state_next      = S_FILL;
        end

        if (finish)
        begin
            if (out_free)
            begin
                done       = 1'b1;
                state_next = S_IDLE;
            end
            else
            begin
                state_next = S_DONE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_FILL;
            col_reg        <= '0;
            row_reg        <= '0;
            top_reg        <= '0;
            tab_cnt_reg    <= '0;
            ovf_reg        <= 1'b0;
            fill_row_reg   <= '0;
            fill_col_reg   <= '0;
            fill_last_reg  <= LAST_ROW;
            fill_color_reg <= RESET_COLOR;
            fill_emit_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            col_reg        <= col_next;
            row_reg        <= row_next;
            top_reg        <= top_next;
            tab_cnt_reg    <= tab_cnt_next;
            ovf_reg        <= ovf_next;
            fill_row_reg   <= fill_row_next;
            fill_col_reg   <= fill_col_next;
            fill_last_reg  <= fill_last_next;
            fill_color_reg <= fill_color_next;
            fill_emit_reg  <= fill_emit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        rd_char_reg  <= rd_char_next;
        rd_color_reg <= rd_color_next;
    end

    // result carries the values that this step leaves behind
    always_comb
    begin
        res.cursor_col = col_next;
        res.cursor_row = row_next;
        res.cell_char  = rd_char_next;
        res.cell_color = rd_color_next;
    end

endmodule

### hw/rtl/text_console_char_writer.sv
// Text console writer: a ROWS x COLUMNS cell memory plus a cursor.
// Transactions on the item channel (item_valid/item_stall, payload item) carry an
// action: put character, clear, set cursor or read cell. Every accepted transaction
// yields exactly one result transaction (result_valid/result_stall) with the cursor
// after the action and, for a read, the addressed cell.
// A line feed past the bottom row also blanks the new bottom row. The cell memory
// does one write or one read per cycle.
// One item is worked on at a time; the next one is taken as soon as the previous
// result sits in the output register.
// After reset the cell memory is filled with spaces in color 7, one cell per cycle,
// and item_stall stays high meanwhile; the color register can be written through
// the apb port during that time.
// While result_stall is high the result is held and a finished item waits inside.
`include "text_console_char_writer_macros.svh"
module text_console_char_writer
    import tcw_pkg::*;
#(
    parameter int COLUMNS    = 80,
    parameter int ROWS       = 25,
    parameter int TAB_SPACES = 4
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               item_valid,
    output logic               item_stall,
    input  tcw_in_t            item,
    output logic               result_valid,
    input  logic               result_stall,
    output tcw_out_t           result
);

    localparam int CW    = $clog2(COLUMNS);
    localparam int RW    = $clog2(ROWS);
    localparam int AW    = RW + CW;
    localparam int DEPTH = ROWS * (2 ** CW);

    logic [CHAR_W-1:0]   text_color;
    logic                out_free;
    logic                ctrl_done;
    tcw_out_t            ctrl_res;
    logic                ram_we;
    logic [AW-1:0]       ram_addr;
    logic [2*CHAR_W-1:0] ram_wdata;
    logic [2*CHAR_W-1:0] ram_rdata;

    logic                result_valid_reg, result_valid_next;
    tcw_out_t            result_reg;

    tcw_apb u_apb (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .text_color (text_color)
    );

    tcw_ram #(
        .WIDTH (2 * CHAR_W),
        .DEPTH (DEPTH)
    ) u_cells (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    tcw_ctrl #(
        .COLUMNS    (COLUMNS),
        .ROWS       (ROWS),
        .TAB_SPACES (TAB_SPACES),
        .AW         (AW)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .text_color (text_color),
        .out_free   (out_free),
        .done       (ctrl_done),
        .res        (ctrl_res),
        .ram_we     (ram_we),
        .ram_addr   (ram_addr),
        .ram_wdata  (ram_wdata),
        .ram_rdata  (ram_rdata)
    );

    // output register: free when empty or being taken this cycle
    assign out_free = !result_valid_reg || !result_stall;

    always_comb
    begin
        result_valid_next = result_valid_reg;
        if (ctrl_done)
        begin
            result_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl_done)
        begin
            result_reg <= ctrl_res;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    `TCW_ASSERT_IMPL(a_cursor_on_screen, result_valid, (result.cursor_col < COLUMNS) && (result.cursor_row < ROWS))
    `TCW_ASSERT_NEXT(a_busy_after_accept, item_valid && !item_stall, item_stall)
    `TCW_ASSERT_IMPL(a_no_overwrite, ctrl_done, !result_valid_reg || !result_stall)

endmodule

### tb/sv/testbench.sv
// self-checking testbench for the text console writer: directed rows, then random actions
module testbench;
    import tcw_pkg::*;

    localparam int SCREEN_COLS = 80;
    localparam int SCREEN_ROWS = 25;
    localparam int TAB_WIDTH   = 4;
    localparam int RANDOM_PHASES    = 6;
    localparam int ITEMS_PER_PHASE  = 175;
    localparam int unsigned CYCLE_LIMIT = 1_000_000;

    typedef struct packed {
        logic       set_color;
        logic [7:0] color;
        tcw_in_t    stim;
        logic       typed;
        tcw_out_t   want;
    } directed_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic item_valid = 1'b0;
    logic item_stall;
    tcw_in_t item = '0;
    logic result_valid;
    logic result_stall = 1'b0;
    tcw_out_t result;

    // console state as the testbench sees it
    logic [15:0] screen_q [SCREEN_COLS*SCREEN_ROWS];
    int cur_c;
    int cur_r;
    logic [7:0] text_color_q;

    tcw_out_t status_queue [$];
    directed_row_t directed_rows [$];
    tcw_out_t got_status;
    tcw_out_t due_status;
    int fail_count = 0;
    int unsigned cycle_count = 0;
    bit steady = 1'b0;

    text_console_char_writer #(
        .COLUMNS   (SCREEN_COLS),
        .ROWS      (SCREEN_ROWS),
        .TAB_SPACES(TAB_WIDTH)
    ) i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .item_valid  (item_valid),
        .item_stall  (item_stall),
        .item        (item),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .result      (result)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        result_stall <= !steady && ($urandom_range(0, 99) < 16);
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            got_status = result;
            if (status_queue.size() == 0)
            begin
                $error("result transaction with nothing pending");
                fail_count++;
            end
            else
            begin
                due_status = status_queue.pop_front();
                if (got_status.cursor_col !== due_status.cursor_col)
                begin
                    $error("cursor_col: expected %0d, got %0d",
                           due_status.cursor_col, got_status.cursor_col);
                    fail_count++;
                end
                if (got_status.cursor_row !== due_status.cursor_row)
                begin
                    $error("cursor_row: expected %0d, got %0d",
                           due_status.cursor_row, got_status.cursor_row);
                    fail_count++;
                end
                if (got_status.cell_char !== due_status.cell_char)
                begin
                    $error("cell_char: expected %0d, got %0d",
                           due_status.cell_char, got_status.cell_char);
                    fail_count++;
                end
                if (got_status.cell_color !== due_status.cell_color)
                begin
                    $error("cell_color: expected %0d, got %0d",
                           due_status.cell_color, got_status.cell_color);
                    fail_count++;
                end
            end
        end
    end

    function automatic void blank_screen(logic [7:0] color);
        for (int k = 0; k < SCREEN_COLS*SCREEN_ROWS; k++)
            screen_q[k] = {color, CH_SPACE};
    endfunction

    // a write off the bottom of the screen is dropped
    function automatic void store_char(logic [7:0] ch);
        if (cur_c < SCREEN_COLS && cur_r < SCREEN_ROWS)
            screen_q[cur_r*SCREEN_COLS + cur_c] = {text_color_q, ch};
    endfunction

    function automatic tcw_out_t apply_console_action(tcw_in_t it);
        tcw_out_t res;
        bit hit;
        res = '0;
        hit = (it.col_in < SCREEN_COLS) && (it.row_in < SCREEN_ROWS);
        case (it.action)
            ACT_PUT:
            begin
                if (it.char_code == CH_NEWLINE)
                begin
                    cur_c = 0;
                    cur_r++;
                end
                else if (it.char_code == CH_RETURN)
                    cur_c = 0;
                else if (it.char_code == CH_TAB)
                begin
                    for (int k = 0; k < TAB_WIDTH; k++)
                    begin
                        store_char(CH_SPACE);
                        cur_c++;
                        if (cur_c >= SCREEN_COLS)
                        begin
                            cur_c = 0;
                            cur_r++;
                        end
                    end
                end
                else
                begin
                    store_char(it.char_code);
                    cur_c++;
                end
                if (cur_c >= SCREEN_COLS)
                begin
                    cur_c = 0;
                    cur_r++;
                end
                // one scroll at most, even after a tab that ran off the bottom
                if (cur_r >= SCREEN_ROWS)
                begin
                    for (int k = 0; k < (SCREEN_ROWS-1)*SCREEN_COLS; k++)
                        screen_q[k] = screen_q[k + SCREEN_COLS];
                    for (int k = (SCREEN_ROWS-1)*SCREEN_COLS; k < SCREEN_ROWS*SCREEN_COLS; k++)
                        screen_q[k] = {text_color_q, CH_SPACE};
                    cur_r = SCREEN_ROWS - 1;
                end
            end
            ACT_CLEAR:
            begin
                blank_screen(text_color_q);
                cur_c = 0;
                cur_r = 0;
            end
            ACT_SETCUR:
            begin
                if (hit)
                begin
                    cur_c = it.col_in;
                    cur_r = it.row_in;
                end
            end
            default:
            begin
                if (hit)
                begin
                    res.cell_char  = screen_q[it.row_in*SCREEN_COLS + it.col_in][7:0];
                    res.cell_color = screen_q[it.row_in*SCREEN_COLS + it.col_in][15:8];
                end
            end
        endcase
        res.cursor_col = COL_W'(cur_c);
        res.cursor_row = ROW_W'(cur_r);
        return res;
    endfunction

    function automatic void add_row(bit set_color, logic [7:0] color, tcw_in_t stim,
                                    bit typed, tcw_out_t want);
        directed_row_t r;
        r.set_color = set_color;
        r.color     = color;
        r.stim      = stim;
        r.typed     = typed;
        r.want      = want;
        directed_rows.push_back(r);
    endfunction

    task automatic send_action(tcw_in_t it, bit typed, tcw_out_t want);
        tcw_out_t predicted;
        while (!steady && $urandom_range(0, 99) < 16)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        item <= it;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        predicted = apply_console_action(it);
        status_queue.push_back(typed ? want : predicted);
    endtask

    task automatic wait_idle();
        item_valid <= 1'b0;
        while (status_queue.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_text_color(logic [7:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= PADDR_W'({REG_TEXT_COLOR, 2'b00});
        pwdata <= {24'd0, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        text_color_q = value;
        // read back through the same port
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata !== {24'd0, value})
        begin
            $error("text_color: expected %0d, got %0d", value, prdata);
            fail_count++;
        end
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    initial
    begin
        tcw_in_t it;
        int pick;
        int sub;
        blank_screen(RESET_COLOR);
        cur_c = 0;
        cur_r = 0;
        text_color_q = RESET_COLOR;

        // reset state and range checks
        add_row(0, 0, tcw_in_t'{ACT_READ, 8'd0, 7'd0, 5'd0}, 1,
                tcw_out_t'{7'd0, 5'd0, CH_SPACE, RESET_COLOR});
        add_row(0, 0, tcw_in_t'{ACT_READ, 8'hFF, 7'd79, 5'd24}, 1,
                tcw_out_t'{7'd0, 5'd0, CH_SPACE, RESET_COLOR});
        add_row(0, 0, tcw_in_t'{ACT_READ, 8'd0, 7'd127, 5'd31}, 1, '0);
        add_row(0, 0, tcw_in_t'{ACT_READ, 8'd0, 7'd80, 5'd0}, 1, '0);
        add_row(0, 0, tcw_in_t'{ACT_READ, 8'd0, 7'd0, 5'd25}, 1, '0);
        add_row(0, 0, tcw_in_t'{ACT_PUT, 8'h41, 7'd127, 5'd31}, 1,
                tcw_out_t'{7'd1, 5'd0, 8'd0, 8'd0});
        add_row(0, 0, tcw_in_t'{ACT_PUT, 8'h00, 7'd0, 5'd0}, 0, '0);
        add_row(0, 0, tcw_in_t'{ACT_PUT, 8'hFF, 7'd0, 5'd0}, 0, '0);
        add_row(0, 0, tcw_in_t'{ACT_READ, 8'd0, 7'd0, 5'd0}, 1,
                tcw_out_t'{7'd3, 5'd0, 8'h41, RESET_COLOR});
        add_row(0, 0, tcw_in_t'{ACT_PUT, CH_RETURN, 7'd0, 5'd0}, 1, '0);
        add_row(0, 0, tcw_in_t'{ACT_SETCUR, 8'd0, 7'd79, 5'd24}, 1,
                tcw_out_t'{7'd79, 5'd24, 8'd0, 8'd0});
        add_row(0, 0, tcw_in_t'{ACT_SETCUR, 8'd0, 7'd80, 5'd0}, 1,
                tcw_out_t'{7'd79, 5'd24, 8'd0, 8'd0});
        add_row(0, 0, tcw_in_t'{ACT_SETCUR, 8'd0, 7'd0, 5'd25}, 1,
                tcw_out_t'{7'd79, 5'd24, 8'd0, 8'd0});
        // last cell: wrap and scroll
        add_row(0, 0, tcw_in_t'{ACT_PUT, 8'h5A, 7'd0, 5'd0}, 0, '0);
        add_row(0, 0, tcw_in_t'{ACT_READ, 8'd0, 7'd79, 5'd23}, 0, '0);
        add_row(0, 0, tcw_in_t'{ACT_READ, 8'd0, 7'd0, 5'd0}, 0, '0);
        add_row(1, 8'hFF, tcw_in_t'{ACT_CLEAR, 8'd0, 7'd0, 5'd0}, 1, '0);
        add_row(0, 0, tcw_in_t'{ACT_READ, 8'd0, 7'd5, 5'd5}, 1,
                tcw_out_t'{7'd0, 5'd0, CH_SPACE, 8'hFF});
        add_row(0, 0, tcw_in_t'{ACT_PUT, CH_TAB, 7'd0, 5'd0}, 0, '0);
        // tab off the bottom: spaces dropped, single scroll
        add_row(0, 0, tcw_in_t'{ACT_SETCUR, 8'd0, 7'd78, 5'd24}, 0, '0);
        add_row(0, 0, tcw_in_t'{ACT_PUT, CH_TAB, 7'd0, 5'd0}, 0, '0);
        add_row(0, 0, tcw_in_t'{ACT_PUT, CH_NEWLINE, 7'd0, 5'd0}, 0, '0);
        add_row(1, 8'h00, tcw_in_t'{ACT_PUT, 8'h78, 7'd0, 5'd0}, 0, '0);
        add_row(0, 0, tcw_in_t'{ACT_SETCUR, 8'd0, 7'd77, 5'd3}, 0, '0);
        add_row(0, 0, tcw_in_t'{ACT_PUT, CH_TAB, 7'd0, 5'd0}, 0, '0);
        add_row(0, 0, tcw_in_t'{ACT_READ, 8'd0, 7'd78, 5'd3}, 0, '0);

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].set_color)
            begin
                wait_idle();
                write_text_color(directed_rows[i].color);
            end
            send_action(directed_rows[i].stim, directed_rows[i].typed, directed_rows[i].want);
        end

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            wait_idle();
            write_text_color(8'($urandom_range(0, 255)));
            steady = (p == 2);
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
            begin
                it.char_code = 8'($urandom_range(0, 255));
                it.col_in    = 7'($urandom_range(0, 127));
                it.row_in    = 5'($urandom_range(0, 31));
                pick = $urandom_range(0, 99);
                sub  = $urandom_range(0, 99);
                if (pick < 55)
                begin
                    it.action = ACT_PUT;
                    if (sub < 10)
                        it.char_code = CH_NEWLINE;
                    else if (sub < 15)
                        it.char_code = CH_RETURN;
                    else if (sub < 23)
                        it.char_code = CH_TAB;
                    else if (sub >= 30)
                        it.char_code = 8'($urandom_range(33, 126));
                end
                else if (pick < 56)
                    it.action = ACT_CLEAR;
                else if (pick < 70)
                begin
                    it.action = ACT_SETCUR;
                    if (sub < 30)
                    begin
                        // near the right edge and the bottom row
                        it.col_in = 7'($urandom_range(SCREEN_COLS-4, SCREEN_COLS-1));
                        it.row_in = 5'($urandom_range(SCREEN_ROWS-2, SCREEN_ROWS-1));
                    end
                    else if (sub < 85)
                    begin
                        it.col_in = 7'($urandom_range(0, SCREEN_COLS-1));
                        it.row_in = 5'($urandom_range(0, SCREEN_ROWS-1));
                    end
                end
                else
                begin
                    it.action = ACT_READ;
                    if (sub < 45)
                    begin
                        it.col_in = 7'($urandom_range(0, SCREEN_COLS-1));
                        it.row_in = ROW_W'(cur_r);
                    end
                    else if (sub < 85)
                    begin
                        it.col_in = 7'($urandom_range(0, SCREEN_COLS-1));
                        it.row_in = 5'($urandom_range(0, SCREEN_ROWS-1));
                    end
                end
                send_action(it, 1'b0, '0);
            end
            steady = 1'b0;
        end

        wait_idle();
        repeat (50) @(posedge clk);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
